// ----- src/incremental_pd_controller_assert.svh -----
// Assertion macros shared by the incremental PD controller RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst_n is low.
`ifndef INCREMENTAL_PD_CONTROLLER_ASSERT_SVH
`define INCREMENTAL_PD_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ipd_pkg.sv -----
// Package for the incremental PD controller: datapath widths, register
// indexes and mode codes. No dependencies.
`timescale 1ns / 1ps

package ipd_pkg;

  localparam int FRAC_BITS   = 8;    // fraction bits of the gains
  localparam int DATA_WIDTH  = 16;   // width of errors and of the output state
  localparam int OUT_SHIFT   = 3;    // extra fraction bits kept in the scaled form
  localparam int UPPER_CLAMP = 1023; // upper limit of the coefficient form

  localparam int IN_W       = 16;    // setpoint and measured fields
  localparam int OUT_W      = 16;    // drive field
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Width of the full-precision increment sum.
  localparam int S_W = DATA_WIDTH + GAIN_W + 4;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [GAIN_W-1:0]     gain_t;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd2;

  localparam logic MODE_DIFF = 1'b0; // scaled difference form
  localparam logic MODE_COEF = 1'b1; // coefficient form with upper clamp

  localparam gain_t KP_RESET = 16'd128;
  localparam gain_t KD_RESET = 16'd13;

endpackage

// ----- src/incremental_pd_controller.sv -----
// Incremental (velocity-form) PD controller, streaming top level.
// Depends on ipd_pkg and on incremental_pd_controller_assert.svh.
`timescale 1ns / 1ps

// Each request carries a setpoint and a measurement and produces one new
// signed 16-bit drive value. The block holds the last two errors and the last
// drive, so requests form one ordered control sequence. Throughput is one
// request per clock cycle while the consumer holds out_tready high. A request
// is captured in the input register and moves into the result register when
// that register is free or is being emptied; its result is presented on the
// output from there. The error, the gain products and the new drive are
// formed in a single combinational pass between the two registers. While a
// finished result waits for the consumer, the input register can still take
// one more request. After that in_tready stays low until the result is taken,
// and in_tready follows out_tready combinationally. Gains are unsigned Q8.8.
// In mode 0 the increment is kp*(e-e1) + kd*(e-2*e1+e2) brought to three
// fraction bits, saturated to 16 bits, shifted right by three and added to the
// previous drive with wrap-around. In mode 1 the same sum is divided by 256
// truncating toward zero, added to the previous drive with wrap-around and
// clamped above at 1023. Configuration must be written only while the block
// is idle.
module incremental_pd_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [15:0] setpoint, [31:16] measured
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [15:0] drive
  // Configuration write port.
  input  logic                            cfg_wen,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ipd_pkg::*;

  `include "incremental_pd_controller_assert.svh"

  localparam int SH0   = FRAC_BITS - OUT_SHIFT;
  localparam int BIAS0 = (1 << SH0) - 1;
  localparam int BIAS1 = (1 << FRAC_BITS) - 1;
  localparam int D2_W  = DATA_WIDTH + 3;

  localparam logic signed [S_W-1:0] SAT_HI =
    {{(S_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [S_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [S_W-1:0] CLAMP_S = S_W'(UPPER_CLAMP);

  // Configuration registers.
  gain_t kp_gain_r;
  gain_t kd_gain_r;
  logic  mode_r;

  // Controller state.
  data_t last_err_r;
  data_t older_err_r;
  data_t last_drive_r;

  // Input register and result register.
  logic                   s1_valid_r;
  logic signed [IN_W-1:0] sp_r;
  logic signed [IN_W-1:0] pv_r;
  logic                   out_valid_r;
  data_t                  out_data_r;

  logic s1_adv;
  logic in_acc;

  // Datapath.
  logic signed [IN_W:0]         diff;
  data_t                        err;
  logic signed [DATA_WIDTH:0]   d1;
  logic signed [D2_W-1:0]       d2;
  logic signed [GAIN_W:0]       kp_s;
  logic signed [GAIN_W:0]       kd_s;
  logic signed [S_W-1:0]        sum;
  logic signed [S_W-1:0]        bias0;
  logic signed [S_W-1:0]        bias1;
  logic signed [S_W-1:0]        q0;
  logic signed [S_W-1:0]        q1;
  data_t                        sat0;
  data_t                        inc0;
  data_t                        inc1;
  data_t                        y0;
  data_t                        y1;
  data_t                        drive_nxt;

  // The input register moves on when the result register is free or is
  // being emptied in this cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // Error and its differences. The error wraps to the data width.
  assign diff = (IN_W+1)'(sp_r) - (IN_W+1)'(pv_r);
  assign err  = DATA_WIDTH'(diff);
  assign d1   = (DATA_WIDTH+1)'(err) - (DATA_WIDTH+1)'(last_err_r);
  assign d2   = D2_W'(err) - (D2_W'(last_err_r) <<< 1) + D2_W'(older_err_r);

  assign kp_s = signed'({1'b0, kp_gain_r});
  assign kd_s = signed'({1'b0, kd_gain_r});

  // Both modes share this sum: (kp+kd)e - (kp+2kd)e1 + kd*e2 expands to
  // exactly kp*(e-e1) + kd*(e-2e1+e2).
  assign sum = S_W'(kp_s) * S_W'(d1) + S_W'(kd_s) * S_W'(d2);

  // Division by a power of two truncating toward zero: add the divisor
  // minus one to negative values before the arithmetic shift.
  assign bias0 = sum[S_W-1] ? S_W'(BIAS0) : '0;
  assign bias1 = sum[S_W-1] ? S_W'(BIAS1) : '0;
  assign q0    = (sum + bias0) >>> SH0;
  assign q1    = (sum + bias1) >>> FRAC_BITS;

  always_comb begin
    if (q0 > SAT_HI) begin
      sat0 = DATA_WIDTH'(SAT_HI);
    end else if (q0 < SAT_LO) begin
      sat0 = DATA_WIDTH'(SAT_LO);
    end else begin
      sat0 = DATA_WIDTH'(q0);
    end
  end

  // The final shift rounds toward minus infinity.
  assign inc0 = sat0 >>> OUT_SHIFT;
  assign inc1 = DATA_WIDTH'(q1);
  assign y0   = inc0 + last_drive_r;
  assign y1   = inc1 + last_drive_r;

  always_comb begin
    if (mode_r == MODE_COEF) begin
      if (S_W'(y1) > CLAMP_S) begin
        drive_nxt = DATA_WIDTH'(UPPER_CLAMP);
      end else begin
        drive_nxt = y1;
      end
    end else begin
      drive_nxt = y0;
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_gain_r <= KP_RESET;
      kd_gain_r <= KD_RESET;
      mode_r    <= MODE_DIFF;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_KP_GAIN: kp_gain_r <= GAIN_W'(cfg_wdata);
        REG_KD_GAIN: kd_gain_r <= GAIN_W'(cfg_wdata);
        REG_MODE:    mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake control and controller state. The state advances exactly when
  // a request moves from the input register into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_err_r   <= '0;
      older_err_r  <= '0;
      last_drive_r <= '0;
    end else begin
      s1_valid_r  <= in_acc || (s1_valid_r && !s1_adv);
      out_valid_r <= s1_adv || (out_valid_r && !out_tready);
      if (s1_adv) begin
        older_err_r  <= last_err_r;
        last_err_r   <= err;
        last_drive_r <= drive_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sp_r <= in_tdata[15:0];
      pv_r <= in_tdata[31:16];
    end
    if (s1_adv) begin
      out_data_r <= drive_nxt;
    end
  end

  `IPD_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_tvalid, "advanced request did not reach output")
  `IPD_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_tready, "input stalled with empty output")
  `IPD_ASSERT_SAME(a_out_is_state, out_valid_r, out_tdata == OUT_W'(last_drive_r), "output and state differ")
  `IPD_ASSERT_SAME(a_coef_clamp, out_valid_r && mode_r == MODE_COEF, $signed(out_tdata) <= 16'sd1023, "clamp violated")
  `IPD_ASSERT_NEXT(a_err_shift, s1_adv, older_err_r == $past(last_err_r), "error history did not shift")

endmodule
